>>> hw/rtl/cdq_pkg.sv
// cdq_pkg: shared types and constants for the circular deque
// item structs, action and status codes, memory request struct
// no dependencies
package cdq_pkg;

	localparam int DEPTH   = 8;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int POS_W   = ADDR_W + 1;
	localparam int CNT_W   = 4;
	localparam int DATA_W  = 32;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(5);

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_REAR  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_REAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		action_t                   action;
		logic signed [DATA_W-1:0]  push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  popped_value;
		status_t                   status;
		logic [CNT_W-1:0]          fill_level;
	} out_item_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] wrap_pos(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		r = (p >= POS_W'(DEPTH)) ? p - POS_W'(DEPTH) : p;
		return r[ADDR_W-1:0];
	endfunction

endpackage

>>> hw/rtl/cdq_ram.sv
// cdq_ram: single-port synchronous ram with registered read
// no dependencies
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> hw/rtl/cdq_ctrl.sv
// cdq_ctrl: head pointer and fill count, full/empty decisions, memory requests
// depends on cdq_pkg
module cdq_ctrl import cdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  in_item_t         item,
	input  logic [CNT_W-1:0] capacity,
	output mem_req_t         mem_req,
	output status_t          status,
	output logic             pop_ok,
	output logic [CNT_W-1:0] fill_next
);

	logic [ADDR_W-1:0] head_q, head_next, head_dec, tail_pos, rear_pos;
	logic [CNT_W-1:0]  fill_q, usable;
	logic              full, empty, is_push;

	always_comb begin
		if (capacity == '0) begin
			usable = CNT_W'(1);
		end else if (capacity > CNT_W'(DEPTH)) begin
			usable = CNT_W'(DEPTH);
		end else begin
			usable = capacity;
		end
	end

	assign full     = fill_q >= usable;
	assign empty    = fill_q == '0;
	assign is_push  = (item.action == ACT_PUSH_FRONT) || (item.action == ACT_PUSH_REAR);
	assign head_dec = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - ADDR_W'(1);
	assign tail_pos = wrap_pos(POS_W'(head_q) + POS_W'(fill_q));
	assign rear_pos = wrap_pos(POS_W'(head_q) + POS_W'(fill_q) - POS_W'(1));

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = head_q;
		mem_req.wdata = item.push_value;
		head_next     = head_q;
		fill_next     = fill_q;
		status        = ST_DONE;
		pop_ok        = 1'b0;
		if (is_push && full) begin
			status = ST_FULL;
		end else if (!is_push && empty) begin
			status = ST_EMPTY;
		end else begin
			unique case (item.action)
				ACT_PUSH_FRONT: begin
					mem_req.we   = accept;
					mem_req.addr = head_dec;
					head_next    = head_dec;
					fill_next    = fill_q + CNT_W'(1);
				end
				ACT_PUSH_REAR: begin
					mem_req.we   = accept;
					mem_req.addr = tail_pos;
					fill_next    = fill_q + CNT_W'(1);
				end
				ACT_POP_FRONT: begin
					mem_req.re   = accept;
					mem_req.addr = head_q;
					head_next    = wrap_pos(POS_W'(head_q) + POS_W'(1));
					fill_next    = fill_q - CNT_W'(1);
					pop_ok       = 1'b1;
				end
				ACT_POP_REAR: begin
					mem_req.re   = accept;
					mem_req.addr = rear_pos;
					fill_next    = fill_q - CNT_W'(1);
					pop_ok       = 1'b1;
				end
				default: begin
					status = ST_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			head_q <= head_next;
			fill_q <= fill_next;
		end
	end

endmodule

>>> hw/rtl/circular_deque.sv
// circular_deque: double-ended queue over an 8-entry ring in synchronous ram
// each result is valid in the cycle after its item is accepted
// throughput: one item per cycle unless out_ready stalls; single ram port, one access at most per item
// reset: head and fill cleared, capacity register set to 5, ram contents undefined
// depends on cdq_pkg, cdq_ctrl, cdq_ram
module circular_deque import cdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	logic [CNT_W-1:0]  cap_q;
	logic              accept;
	mem_req_t          mem_req;
	status_t           status, status_s1;
	logic              pop_ok, pop_ok_s1, valid_s1;
	logic [CNT_W-1:0]  fill_next, fill_s1;
	logic [DATA_W-1:0] rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || out_ready;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.capacity  (cap_q),
		.mem_req   (mem_req),
		.status    (status),
		.pop_ok    (pop_ok),
		.fill_next (fill_next)
	);

	cdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			pop_ok_s1 <= pop_ok;
			fill_s1   <= fill_next;
		end
	end

	assign out_valid             = valid_s1;
	assign out_data.popped_value = pop_ok_s1 ? rdata : '0;
	assign out_data.status       = status_s1;
	assign out_data.fill_level   = fill_s1;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.fill_level <= CNT_W'(DEPTH))
		else $error("fill level above depth");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |-> out_data.fill_level == '0)
		else $error("empty refusal with nonzero fill");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_DONE |-> out_data.popped_value == '0)
		else $error("refused item carries a popped value");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");
`endif

endmodule

>>> tb/tb.sv
// tb: self-checking testbench for circular_deque with a valid/ready driver and monitor
// predicts every reply with its own deque model and checks it field by field
// depends on cdq_pkg and the circular_deque rtl
module tb;
	import cdq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	circular_deque dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	in_item_t  op_queue[$];
	out_item_t predicted_replies[$];
	out_item_t want;
	int        items_queued = 0;
	int        results_seen = 0;
	int        errors = 0;
	int        in_wait = 0;
	int        out_hold = 0;
	int        out_draw = 0;
	bit        snd_steady = 1'b0;
	bit        rcv_steady = 1'b0;

	// deque model state
	logic [DATA_W-1:0] slots [DEPTH];
	int                head_pos = 0;
	int                fill_cnt = 0;
	logic [CNT_W-1:0]  cap_reg = CAP_RESET;

	function automatic out_item_t deque_predict(input in_item_t it);
		out_item_t r;
		int        lim;
		int        pos;
		lim = (cap_reg == 0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
		r.popped_value = '0;
		r.status = ST_DONE;
		if (it.action == ACT_PUSH_FRONT || it.action == ACT_PUSH_REAR) begin
			if (fill_cnt >= lim) begin
				r.status = ST_FULL;
			end else if (it.action == ACT_PUSH_FRONT) begin
				head_pos = (head_pos + DEPTH - 1) % DEPTH;
				slots[head_pos] = it.push_value;
				fill_cnt++;
			end else begin
				pos = (head_pos + fill_cnt) % DEPTH;
				slots[pos] = it.push_value;
				fill_cnt++;
			end
		end else begin
			if (fill_cnt == 0) begin
				r.status = ST_EMPTY;
			end else if (it.action == ACT_POP_FRONT) begin
				r.popped_value = slots[head_pos];
				head_pos = (head_pos + 1) % DEPTH;
				fill_cnt--;
			end else begin
				pos = (head_pos + fill_cnt - 1) % DEPTH;
				r.popped_value = slots[pos];
				fill_cnt--;
			end
		end
		r.fill_level = CNT_W'(fill_cnt);
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_wait <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predicted_replies.push_back(deque_predict(in_data));
			if (in_wait > 0) begin
				in_wait <= in_wait - 1;
				in_valid <= 1'b0;
			end else if (op_queue.size() > 0) begin
				in_data <= op_queue.pop_front();
				in_valid <= 1'b1;
				in_wait <= snd_steady ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_hold <= 0;
		end else if (out_valid && out_ready) begin
			results_seen++;
			if (predicted_replies.size() == 0) begin
				$display("%0t: reply with no item outstanding: %p", $time, out_data);
				errors++;
			end else begin
				want = predicted_replies.pop_front();
				if (out_data.popped_value !== want.popped_value) begin
					$display("%0t: popped_value expected %0d got %0d", $time,
						want.popped_value, out_data.popped_value);
					errors++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, out_data.status);
					errors++;
				end
				if (out_data.fill_level !== want.fill_level) begin
					$display("%0t: fill_level expected %0d got %0d", $time,
						want.fill_level, out_data.fill_level);
					errors++;
				end
			end
			out_draw = rcv_steady ? 0 : $urandom_range(0, 4);
			out_hold <= out_draw;
			out_ready <= (out_draw == 0);
		end else if (!out_ready) begin
			if (out_hold <= 1)
				out_ready <= 1'b1;
			out_hold <= out_hold - 1;
		end
	end

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_item(input action_t a, input logic [DATA_W-1:0] v);
		in_item_t it;
		it.action = a;
		it.push_value = v;
		op_queue.push_back(it);
		items_queued++;
	endtask

	task automatic wait_idle();
		while (results_seen != items_queued || op_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cap_reg = v;
	endtask

	initial begin
		logic [CNT_W-1:0] caps [10];
		int               push_pct;
		bit               do_push;
		caps = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd12, 4'd7, 4'd3, 4'd9, 4'd4};
		caps[9] = CNT_W'($urandom_range(0, 15));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity, empty refusals, fill past the limit, drain both ends
		add_item(ACT_POP_FRONT, rand_value());
		add_item(ACT_POP_REAR, rand_value());
		add_item(ACT_PUSH_FRONT, 32'h7fff_ffff);
		add_item(ACT_PUSH_REAR, 32'h8000_0000);
		add_item(ACT_PUSH_FRONT, '1);
		add_item(ACT_PUSH_REAR, '0);
		add_item(ACT_PUSH_FRONT, $urandom);
		add_item(ACT_PUSH_REAR, $urandom);
		add_item(ACT_POP_FRONT, rand_value());
		add_item(ACT_POP_REAR, rand_value());
		add_item(ACT_POP_FRONT, rand_value());
		add_item(ACT_POP_REAR, rand_value());
		add_item(ACT_POP_REAR, rand_value());
		add_item(ACT_POP_FRONT, rand_value());
		wait_idle();

		// fill deep, then lower the capacity below the fill
		write_capacity(4'd8);
		for (int i = 0; i < 7; i++)
			add_item((i % 2) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, rand_value());
		wait_idle();
		write_capacity(4'd3);
		add_item(ACT_PUSH_REAR, rand_value());
		add_item(ACT_POP_FRONT, rand_value());
		add_item(ACT_POP_REAR, rand_value());
		add_item(ACT_PUSH_FRONT, rand_value());
		add_item(ACT_POP_REAR, rand_value());
		add_item(ACT_POP_FRONT, rand_value());
		add_item(ACT_POP_FRONT, rand_value());
		add_item(ACT_PUSH_REAR, rand_value());
		add_item(ACT_PUSH_FRONT, rand_value());
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			write_capacity(caps[ph]);
			snd_steady = (ph % 3 == 1);
			rcv_steady = (ph % 4 == 2);
			push_pct = 50;
			for (int n = 0; n < 112; n++) begin
				if (n % 16 == 0)
					push_pct = 20 + 30 * $urandom_range(0, 2);
				do_push = ($urandom_range(1, 100) <= push_pct);
				if (do_push)
					add_item($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT,
						rand_value());
				else
					add_item($urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT,
						rand_value());
			end
			wait_idle();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
